>>> rtl/ccb_pkg.sv
// Package for the canonical code table builder: port field widths, item kinds,
// status codes, controller states and the controller-to-datapath command types.
// No dependencies.
package ccb_pkg;

    // Fixed field widths of the stream items.
    localparam int unsigned FUNC_W      = 2;
    localparam int unsigned SYM_W       = 8;
    localparam int unsigned BITS_W      = 5;
    localparam int unsigned CODE_W      = 31;
    localparam int unsigned STAT_W      = 2;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_USED_W  = CODE_W + BITS_W + BITS_W + STAT_W;
    localparam int unsigned OUT_TDATA_W = 48;

    // Item kinds carried on the input tuser.
    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD  = 2'd0,
        FN_BUILD = 2'd1,
        FN_READ  = 2'd2
    } t_ccb_func;

    // Build status reported with every result.
    typedef enum logic [STAT_W-1:0] {
        BS_OK       = 2'd0,
        BS_EMPTY    = 2'd1,
        BS_OVERFLOW = 2'd2
    } t_ccb_bstat;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COUNT,
        ST_CNT_END,
        ST_KRAFT,
        ST_CODES,
        ST_ASSIGN,
        ST_DONE
    } t_ccb_state;

    // Datapath sweep or walk performed in a cycle.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_COUNT,
        OP_KRAFT,
        OP_CODES,
        OP_ASSIGN
    } t_ccb_op;

    // Source loaded into the output register.
    typedef enum logic [1:0] {
        OUT_HOLD,
        OUT_PLAIN,
        OUT_READ,
        OUT_BUILD
    } t_ccb_out;

    typedef struct packed {
        t_ccb_op  op;
        logic     len_wr;      // store the length of a load item
        logic     rd_issue;    // look up the symbol of a read item
        logic     build_init;  // clear counts and walk registers
        t_ccb_out out_ctl;
    } t_ccb_cmd;

    typedef struct packed {
        logic addr_last;   // symbol sweep is at its final entry
        logic len_at_top;  // length walk is at the longest allowed length
        logic len_at_one;  // length walk is at length one
    } t_ccb_stat;

endpackage

>>> rtl/ccb_ctrl.sv
// Controller of the canonical code table builder: item handshake, output valid
// and the state machine that sequences the build sweeps.
// Depends on ccb_pkg.
module ccb_ctrl
    import ccb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic                  i_out_ready,
    input  t_ccb_stat             i_dp_stat,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output t_ccb_cmd              o_cmd
);

    t_ccb_state r_state;
    t_ccb_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;

    // An item enters only when idle and the output slot is free or draining.
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_dp_stat.addr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    case (t_ccb_func'(i_func))
                        FN_BUILD: n_state = ST_COUNT;
                        FN_READ:  n_state = ST_READ;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:    n_state = ST_IDLE;
            ST_COUNT: begin
                if (i_dp_stat.addr_last) n_state = ST_CNT_END;
            end
            ST_CNT_END: n_state = ST_KRAFT;
            ST_KRAFT: begin
                if (i_dp_stat.len_at_top) n_state = ST_CODES;
            end
            ST_CODES: begin
                if (i_dp_stat.len_at_one) n_state = ST_ASSIGN;
            end
            ST_ASSIGN: begin
                if (i_dp_stat.addr_last) n_state = ST_DONE;
            end
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '{op: OP_NONE, len_wr: 1'b0, rd_issue: 1'b0, build_init: 1'b0,
                  out_ctl: OUT_HOLD};
        case (r_state)
            ST_CLEAR:  o_cmd.op = OP_CLEAR;
            ST_IDLE: begin
                if (accept) begin
                    case (t_ccb_func'(i_func))
                        FN_LOAD: begin
                            o_cmd.len_wr  = 1'b1;
                            o_cmd.out_ctl = OUT_PLAIN;
                        end
                        FN_BUILD: o_cmd.build_init = 1'b1;
                        FN_READ:  o_cmd.rd_issue   = 1'b1;
                        default:  o_cmd.out_ctl    = OUT_PLAIN;
                    endcase
                end
            end
            ST_READ:   o_cmd.out_ctl = OUT_READ;
            ST_COUNT:  o_cmd.op      = OP_COUNT;
            ST_KRAFT:  o_cmd.op      = OP_KRAFT;
            ST_CODES:  o_cmd.op      = OP_CODES;
            ST_ASSIGN: o_cmd.op      = OP_ASSIGN;
            ST_DONE:   o_cmd.out_ctl = OUT_BUILD;
            default:   o_cmd.op      = OP_NONE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_ctl != OUT_HOLD) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

endmodule

>>> rtl/ccb_dpath.sv
// Datapath of the canonical code table builder: length and code memories,
// per-length counters, Kraft accumulator, next-code registers and output register.
// Depends on ccb_pkg.
module ccb_dpath
    import ccb_pkg::*;
#(
    parameter int unsigned ALPHABET  = 256,
    parameter int unsigned LEN_LIMIT = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ccb_cmd           i_cmd,
    input  logic [SYM_W-1:0]   i_sym,
    input  logic [BITS_W-1:0]  i_len,
    output t_ccb_stat          o_stat,
    output logic [CODE_W-1:0]  o_code,
    output logic [BITS_W-1:0]  o_code_bits,
    output logic [BITS_W-1:0]  o_longest,
    output logic [STAT_W-1:0]  o_status
);

    localparam int unsigned AW      = $clog2(ALPHABET);
    localparam int unsigned LEN_TOP = (LEN_LIMIT - 1 > 31) ? 31 : LEN_LIMIT - 1;
    localparam int unsigned LW      = $clog2(LEN_TOP + 1);
    localparam int unsigned CW      = LEN_TOP;
    localparam int unsigned CNT_W   = $clog2(ALPHABET + 1);
    localparam int unsigned KR_W    = LEN_TOP + 2;
    localparam int unsigned KS_W    = ((KR_W + 1 > CNT_W) ? KR_W + 1 : CNT_W) + 1;
    localparam int unsigned XW      = ((AW > SYM_W) ? AW : SYM_W) + 1;
    localparam logic [KR_W-1:0] KR_ONE = KR_W'(1) << LEN_TOP;
    localparam logic [KR_W-1:0] KR_SAT = KR_ONE | KR_W'(1);

    // Memories.
    logic [LW-1:0]    r_lmem [0:ALPHABET-1];
    logic [CW-1:0]    r_cmem [0:ALPHABET-1];
    logic [LW-1:0]    r_ls_q;
    logic [CW-1:0]    r_cs_q;

    // Build state.
    logic [CNT_W-1:0] r_cnt  [0:LEN_TOP];
    logic [CNT_W-1:0] r_next [0:LEN_TOP];
    logic [AW-1:0]    r_addr;
    logic [AW-1:0]    r_paddr;
    logic             r_pv;
    logic             r_pasn;
    logic [LW-1:0]    r_len;
    logic [KR_W-1:0]  r_kraft;
    logic [CNT_W-1:0] r_a;
    logic [LW-1:0]    r_longest;
    logic [STAT_W-1:0] r_status;
    logic             r_rd_ok;

    // Output register.
    logic [CODE_W-1:0] r_o_code;
    logic [BITS_W-1:0] r_o_bits;
    logic [BITS_W-1:0] r_o_longest;
    logic [STAT_W-1:0] r_o_status;

    logic [XW-1:0]    sym_x;
    logic             sym_ok;
    logic [AW-1:0]    sym_idx;
    logic [LW-1:0]    len_sat;
    logic             sweep;
    logic [AW-1:0]    lrd_addr;
    logic             lwe;
    logic [AW-1:0]    lwa;
    logic [LW-1:0]    lwd;
    logic             cwe;
    logic [AW-1:0]    cwa;
    logic [CW-1:0]    cwd;
    logic [CNT_W-1:0] cur_cnt;
    logic [KS_W-1:0]  k_sum;
    logic [CNT_W:0]   a_sum;
    logic [CNT_W-1:0] asn_next;
    logic [CW:0]      asn_mask_w;
    logic [CW-1:0]    asn_code;
    logic [STAT_W-1:0] build_stat;

    assign sym_x   = XW'(i_sym);
    assign sym_ok  = sym_x < XW'(ALPHABET);
    assign sym_idx = sym_x[AW-1:0];
    assign len_sat = (i_len > BITS_W'(LEN_TOP)) ? LW'(LEN_TOP) : LW'(i_len);
    assign sweep   = (i_cmd.op == OP_COUNT) || (i_cmd.op == OP_ASSIGN);
    assign lrd_addr = sweep ? r_addr : sym_idx;

    assign o_stat.addr_last  = (r_addr == AW'(ALPHABET - 1));
    assign o_stat.len_at_top = (r_len == LW'(LEN_TOP));
    assign o_stat.len_at_one = (r_len == LW'(1));

    assign cur_cnt = r_cnt[r_len];
    assign k_sum   = (KS_W'(r_kraft) << 1) + KS_W'(cur_cnt);
    assign a_sum   = (CNT_W + 1)'(r_a) + (CNT_W + 1)'(cur_cnt);

    // Code of the symbol coming out of the length memory, masked to its length.
    assign asn_next   = r_next[r_ls_q];
    assign asn_mask_w = ((CW + 1)'(1) << r_ls_q) - (CW + 1)'(1);
    assign asn_code   = (r_ls_q == '0) ? '0 : (CW'(asn_next) & asn_mask_w[CW-1:0]);

    always_comb begin
        if (r_longest == '0) begin
            build_stat = BS_EMPTY;
        end else if (r_kraft > KR_ONE) begin
            build_stat = BS_OVERFLOW;
        end else begin
            build_stat = BS_OK;
        end
    end

    // Memory write port selection.
    always_comb begin
        lwe = 1'b0;
        lwa = sym_idx;
        lwd = len_sat;
        cwe = 1'b0;
        cwa = r_paddr;
        cwd = asn_code;
        if (i_cmd.op == OP_CLEAR) begin
            lwe = 1'b1;
            lwa = r_addr;
            lwd = '0;
            cwe = 1'b1;
            cwa = r_addr;
            cwd = '0;
        end else begin
            lwe = i_cmd.len_wr && sym_ok;
            cwe = r_pv && r_pasn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lwe) r_lmem[lwa] <= lwd;
        r_ls_q <= r_lmem[lrd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cwe) r_cmem[cwa] <= cwd;
        r_cs_q <= r_cmem[sym_idx];
    end

    // Control registers of the sweeps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_pv      <= 1'b0;
            r_pasn    <= 1'b0;
            r_longest <= '0;
            r_status  <= BS_OK;
        end else begin
            if (sweep || (i_cmd.op == OP_CLEAR)) begin
                r_addr <= o_stat.addr_last ? '0 : r_addr + AW'(1);
            end
            r_pv   <= sweep;
            r_pasn <= (i_cmd.op == OP_ASSIGN);
            if (i_cmd.build_init) begin
                r_longest <= '0;
            end else if ((i_cmd.op == OP_KRAFT) && (cur_cnt != '0)) begin
                r_longest <= r_len;
            end
            if (i_cmd.out_ctl == OUT_BUILD) r_status <= build_stat;
        end
    end

    // Walk registers, counters and next codes.
    always_ff @(posedge i_clk) begin
        r_paddr <= r_addr;
        if (i_cmd.rd_issue) r_rd_ok <= sym_ok;
        if (i_cmd.build_init) begin
            for (int i = 0; i <= LEN_TOP; i++) r_cnt[i] <= '0;
            r_len   <= LW'(1);
            r_kraft <= '0;
            r_a     <= '0;
        end else begin
            if (r_pv && !r_pasn && (r_ls_q != '0)) begin
                r_cnt[r_ls_q] <= r_cnt[r_ls_q] + CNT_W'(1);
            end
            if (i_cmd.op == OP_KRAFT) begin
                // Horner form of the Kraft sum, saturated just above one.
                r_kraft <= (k_sum > KS_W'(KR_SAT)) ? KR_SAT : k_sum[KR_W-1:0];
                r_len   <= o_stat.len_at_top ? LW'(LEN_TOP) : r_len + LW'(1);
            end
            if (i_cmd.op == OP_CODES) begin
                r_next[r_len] <= r_a;
                r_a           <= a_sum[CNT_W:1];
                r_len         <= r_len - LW'(1);
            end
            if (r_pv && r_pasn && (r_ls_q != '0)) begin
                r_next[r_ls_q] <= asn_next + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.out_ctl)
            OUT_PLAIN: begin
                r_o_code    <= '0;
                r_o_bits    <= '0;
                r_o_longest <= BITS_W'(r_longest);
                r_o_status  <= r_status;
            end
            OUT_READ: begin
                r_o_code    <= r_rd_ok ? CODE_W'(r_cs_q) : '0;
                r_o_bits    <= r_rd_ok ? BITS_W'(r_ls_q) : '0;
                r_o_longest <= BITS_W'(r_longest);
                r_o_status  <= r_status;
            end
            OUT_BUILD: begin
                r_o_code    <= '0;
                r_o_bits    <= '0;
                r_o_longest <= BITS_W'(r_longest);
                r_o_status  <= build_stat;
            end
            default: begin
                r_o_code    <= r_o_code;
            end
        endcase
    end

    assign o_code      = r_o_code;
    assign o_code_bits = r_o_bits;
    assign o_longest   = r_o_longest;
    assign o_status    = r_o_status;

endmodule

>>> rtl/canonical_code_table_builder_unit.sv
// Top level of the canonical code table builder: stream ports, controller and
// datapath. Depends on ccb_pkg, ccb_ctrl and ccb_dpath.
//
//  Channel   Direction  Ports                 Carries
//  s_axis    in         tvalid tready tdata   tdata: symbol, code_length
//                       tuser                 tuser: func (load, build, read)
//  m_axis    out        tvalid tready tdata   tdata: code, code_bits,
//                                             longest_length, status
//
// Every item gives exactly one result. Loads (and the unused func value) stream
// at one item per cycle while the output is ready. A read item passes through
// the registered read port of the code and length memories before its result.
// A build item runs one sweep of the length memory to count lengths, an
// ascending length walk for the longest length and the Kraft sum, a descending
// walk for the first code of each length and a second sweep that writes the
// code memory.
// After reset the block clears both memories with tready low.
// A result waits in the output register while the output is stalled; the next
// item is taken in the cycle in which the pending result leaves.
module canonical_code_table_builder_unit
    import ccb_pkg::*;
#(
    parameter int unsigned ALPHABET  = 256,
    parameter int unsigned LEN_LIMIT = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // symbol[7:0], code_length[12:8]
    input  logic [FUNC_W-1:0]      i_s_axis_tuser,   // func[1:0]
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // code[30:0], code_bits[35:31],
                                                     // longest_length[40:36], status[42:41]
);

    t_ccb_cmd          cmd;
    t_ccb_stat         dp_stat;
    logic [CODE_W-1:0] code;
    logic [BITS_W-1:0] code_bits;
    logic [BITS_W-1:0] longest;
    logic [STAT_W-1:0] status;

    ccb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_func      (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .i_dp_stat   (dp_stat),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    ccb_dpath #(
        .ALPHABET  (ALPHABET),
        .LEN_LIMIT (LEN_LIMIT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sym       (i_s_axis_tdata[SYM_W-1:0]),
        .i_len       (i_s_axis_tdata[SYM_W+BITS_W-1:SYM_W]),
        .o_stat      (dp_stat),
        .o_code      (code),
        .o_code_bits (code_bits),
        .o_longest   (longest),
        .o_status    (status)
    );

    // Unused upper bits of the result word are zero.
    assign o_m_axis_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                             status, longest, code_bits, code};

endmodule

>>> rtl/ccb_checker.sv
// Port-level checker for the canonical code table builder, attached to the
// top level by the bind statement at the end. Depends on ccb_pkg.
module ccb_checker
    import ccb_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [FUNC_W-1:0]      i_s_axis_tuser,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic in_acc;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result changed while stalled");

    // A load is answered in the next cycle with a zero code and length.
    a_load_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tuser == FN_LOAD) |=>
            (o_m_axis_tvalid && o_m_axis_tdata[35:0] == 36'd0))
        else $error("load result missing or not zero");

    // A read goes through the registered memory port and the output register,
    // with no result and no new item in between.
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tuser == FN_READ) |=>
            (!o_m_axis_tvalid && !o_s_axis_tready) ##1 o_m_axis_tvalid)
        else $error("read result latency wrong");

    // An empty table has no longest length.
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[42:41] == BS_EMPTY) |->
            (o_m_axis_tdata[40:36] == 5'd0))
        else $error("empty status with nonzero longest length");

endmodule

bind canonical_code_table_builder_unit ccb_checker u_ccb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> tb/canonical_code_table_builder_unit_tb.sv
// Self-checking testbench for canonical_code_table_builder_unit: drives load, build
// and read items on the input stream and checks every result against its own model.
// Depends on ccb_pkg and the canonical_code_table_builder_unit RTL.
module canonical_code_table_builder_unit_tb;
    import ccb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ALPHABET    = 256;
    localparam int unsigned LEN_LIMIT   = 32;
    localparam int unsigned TOP_LEN     = (LEN_LIMIT - 1 > 31) ? 31 : LEN_LIMIT - 1;
    localparam int unsigned ITEM_TARGET = 450;
    localparam int unsigned MAX_IDLE    = 4;
    localparam int unsigned DRAIN_WAIT  = 10;
    // The one func encoding the block does not define; a load's result, no length stored.
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    // Result fields, code in the lowest bits as on the output tdata.
    typedef struct packed {
        t_ccb_bstat       status;
        logic [BITS_W-1:0] longest;
        logic [BITS_W-1:0] bits;
        logic [CODE_W-1:0] code;
    } t_code_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;     // symbol[7:0], code_length[12:8]
    logic [FUNC_W-1:0]      s_tuser = FN_LOAD; // func[1:0]
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // code[30:0], code_bits[35:31],
                                              // longest_length[40:36], status[42:41]

    // Model state of the table builder.
    logic [BITS_W-1:0] sym_len  [ALPHABET];
    logic [CODE_W-1:0] sym_code [ALPHABET];
    logic [BITS_W-1:0] built_longest;
    t_ccb_bstat        built_status;

    t_code_result pending_results[$];
    int unsigned  sent_items;
    int unsigned  fail_count;
    bit           steady;  // no idling on either side while set

    canonical_code_table_builder_unit #(
        .ALPHABET (ALPHABET),
        .LEN_LIMIT(LEN_LIMIT)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Canonical assignment: longest length first, ascending symbol within a length.
    function automatic void build_code_table();
        int unsigned counts [32];
        logic [63:0] next_code [32];
        logic [63:0] kraft;
        logic [63:0] after;
        int unsigned prev;
        bit          first;
        int          len;
        int          s;

        foreach (counts[i]) begin
            counts[i]    = 0;
            next_code[i] = '0;
        end
        for (s = 0; s < ALPHABET; s++) begin
            sym_code[s] = '0;
            if (sym_len[s] != 0 && sym_len[s] <= TOP_LEN)
                counts[sym_len[s]]++;
        end
        built_longest = '0;
        for (len = TOP_LEN; len >= 1; len--) begin
            if (counts[len] != 0) begin
                built_longest = len[BITS_W-1:0];
                break;
            end
        end
        if (built_longest == 0) begin
            built_status = BS_EMPTY;
            return;
        end
        kraft = '0;
        after = '0;
        prev  = 0;
        first = 1'b1;
        for (len = built_longest; len >= 1; len--) begin
            if (counts[len] == 0)
                continue;
            kraft += 64'(counts[len]) << (built_longest - len);
            if (first) begin
                next_code[len] = '0;
                first = 1'b0;
            end else begin
                next_code[len] = after >> (prev - len);
            end
            after = next_code[len] + 64'(counts[len]);
            prev  = len;
        end
        built_status = (kraft > (64'd1 << built_longest)) ? BS_OVERFLOW : BS_OK;
        for (s = 0; s < ALPHABET; s++) begin
            len = sym_len[s];
            if (len == 0 || len > TOP_LEN)
                continue;
            sym_code[s] = CODE_W'(next_code[len] & ((64'd1 << len) - 64'd1));
            next_code[len]++;
        end
    endfunction

    // Applies one accepted item to the model and queues its result.
    function automatic void predict_item(logic [FUNC_W-1:0] func, logic [SYM_W-1:0] sym,
                                         logic [BITS_W-1:0] len);
        t_code_result r;

        r = '0;
        case (func)
            FN_LOAD: begin
                if (sym < ALPHABET)
                    sym_len[sym] = (len > TOP_LEN) ? BITS_W'(TOP_LEN) : len;
            end
            FN_BUILD: build_code_table();
            FN_READ: begin
                if (sym < ALPHABET) begin
                    r.code = sym_code[sym];
                    r.bits = sym_len[sym];
                end
            end
            default: ;
        endcase
        r.longest = built_longest;
        r.status  = built_status;
        pending_results = {pending_results, r};
    endfunction

    // Offers one item after a random gap and returns at the edge that accepts it.
    task automatic send_item(logic [FUNC_W-1:0] func, logic [SYM_W-1:0] sym,
                             logic [BITS_W-1:0] len);
        int unsigned gap;

        @(negedge i_clk);
        gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {3'b000, len, sym};
        do @(posedge i_clk); while (!s_ready);
        predict_item(func, sym, len);
        sent_items++;
    endtask

    // Result sink: a random stall before each result, then ready until one is taken.
    initial begin : result_sink
        int unsigned stall;

        forever begin
            @(negedge i_clk);
            stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && m_valid && m_ready));
        end
    end

    // Compares each accepted result with the oldest queued one.
    always @(posedge i_clk) begin : result_check
        t_code_result got;
        t_code_result want;

        if (i_rst_n && m_valid && m_ready) begin
            got = t_code_result'(m_tdata[OUT_USED_W-1:0]);
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: tdata 0x%0h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.code !== want.code) begin
                    $error("code: expected %0d, actual %0d", want.code, got.code);
                    fail_count++;
                end
                if (got.bits !== want.bits) begin
                    $error("code_bits: expected %0d, actual %0d", want.bits, got.bits);
                    fail_count++;
                end
                if (got.longest !== want.longest) begin
                    $error("longest_length: expected %0d, actual %0d",
                           want.longest, got.longest);
                    fail_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [SYM_W-1:0] pick_used_symbol();
        logic [SYM_W-1:0] used[$];

        for (int s = 0; s < ALPHABET; s++)
            if (sym_len[s] != 0)
                used = {used, SYM_W'(s)};
        if (used.size() == 0)
            return SYM_W'($urandom_range(0, ALPHABET - 1));
        return used[$urandom_range(0, used.size() - 1)];
    endfunction

    // Zeroes every length the model holds, so the next table starts empty.
    task automatic wipe_lengths();
        for (int s = 0; s < ALPHABET; s++)
            if (sym_len[s] != 0)
                send_item(FN_LOAD, SYM_W'(s), '0);
    endtask

    // Reads, mostly of used symbols, with an occasional load between them.
    task automatic read_back(int unsigned count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0)
                send_item(FN_LOAD, pick_used_symbol(), BITS_W'($urandom_range(0, 31)));
            if ($urandom_range(0, 3) != 0)
                send_item(FN_READ, pick_used_symbol(), BITS_W'($urandom()));
            else
                send_item(FN_READ, SYM_W'($urandom()), BITS_W'($urandom()));
        end
    endtask

    // Lengths of a full binary tree on distinct symbols, sometimes with one leaf left out.
    task automatic load_complete_code();
        int unsigned leaf_len[$];
        int unsigned n;
        int unsigned idx;
        int unsigned l;
        int unsigned sym;

        wipe_lengths();
        n = $urandom_range(2, 40);
        leaf_len = {leaf_len, 0};
        while (leaf_len.size() < n) begin
            // Favoring the newest leaf grows long chains, down to the longest length.
            idx = $urandom_range(0, 1) ? leaf_len.size() - 1
                                       : $urandom_range(0, leaf_len.size() - 1);
            if (leaf_len[idx] < TOP_LEN) begin
                l = leaf_len[idx] + 1;
                leaf_len[idx] = l;
                leaf_len = {leaf_len, l};
            end
        end
        if ($urandom_range(0, 3) == 0)
            void'(leaf_len.pop_front());
        foreach (leaf_len[i]) begin
            do sym = $urandom_range(0, ALPHABET - 1); while (sym_len[sym] != 0);
            send_item(FN_LOAD, SYM_W'(sym), BITS_W'(leaf_len[i]));
        end
    endtask

    task automatic test_before_build();
        // Reads before any build see zero codes and an ok status; then an empty build.
        send_item(FN_READ, 8'd0, 5'd0);
        send_item(FN_READ, 8'd255, 5'd31);
        send_item(FN_BUILD, 8'd0, 5'd0);
        send_item(FN_READ, 8'd7, 5'd0);
    endtask

    task automatic test_directed_cases();
        // Field extremes and the unused func value.
        send_item(FN_LOAD, 8'd0, 5'd31);
        send_item(FN_LOAD, 8'd255, 5'd31);
        send_item(FN_LOAD, 8'd128, 5'd1);
        send_item(FN_UNUSED, 8'd128, 5'd0);
        send_item(FN_BUILD, 8'hFF, 5'd31);
        send_item(FN_READ, 8'd0, 5'd0);
        send_item(FN_READ, 8'd255, 5'd0);
        send_item(FN_READ, 8'd128, 5'd0);
        // Three codes of length one overflow the code space.
        send_item(FN_LOAD, 8'd1, 5'd1);
        send_item(FN_LOAD, 8'd2, 5'd1);
        send_item(FN_BUILD, 8'd0, 5'd0);
        send_item(FN_READ, 8'd2, 5'd0);
        send_item(FN_READ, 8'd1, 5'd0);
        // A load after the build changes the length but keeps the built code.
        send_item(FN_LOAD, 8'd1, 5'd0);
        send_item(FN_READ, 8'd1, 5'd0);
        send_item(FN_READ, 8'd3, 5'd0);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (24)
            send_item(FN_LOAD, SYM_W'($urandom()), BITS_W'($urandom_range(1, 8)));
        send_item(FN_BUILD, SYM_W'($urandom()), BITS_W'($urandom()));
        read_back(24);
        steady = 1'b0;
    endtask

    task automatic test_random_tables();
        int unsigned mode;

        while (sent_items < ITEM_TARGET) begin
            mode = $urandom_range(0, 9);
            if (mode <= 5) begin
                load_complete_code();
            end else if (mode <= 7) begin
                repeat ($urandom_range(1, 20))
                    send_item(FN_LOAD, SYM_W'($urandom()), BITS_W'($urandom_range(0, 31)));
            end else if (mode == 8) begin
                wipe_lengths();
            end else begin
                // Noise: any func with random fields, no build of our own after it.
                repeat ($urandom_range(3, 10))
                    send_item(FUNC_W'($urandom_range(0, 3)), SYM_W'($urandom()),
                              BITS_W'($urandom()));
            end
            if (mode != 9) begin
                send_item(FN_BUILD, SYM_W'($urandom()), BITS_W'($urandom()));
                read_back($urandom_range(5, 20));
            end
        end
    endtask

    initial begin
        foreach (sym_len[i]) begin
            sym_len[i]  = '0;
            sym_code[i] = '0;
        end
        built_longest = '0;
        built_status  = BS_OK;
        sent_items    = 0;
        fail_count    = 0;
        steady        = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_before_build();
        test_directed_cases();
        test_back_to_back();
        test_random_tables();

        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/ccb_pkg.sv
rtl/ccb_ctrl.sv
rtl/ccb_dpath.sv
rtl/canonical_code_table_builder_unit.sv
rtl/ccb_checker.sv
tb/canonical_code_table_builder_unit_tb.sv
